FILE: design/cmfb_pkg.sv
package cmfb_pkg;

   // Command kinds, coded as on the request mode port
   typedef enum logic [1:0] {
      CMD_ENABLE   = 2'd0,
      CMD_DISABLE  = 2'd1,
      CMD_MIT      = 2'd2,
      CMD_FEEDBACK = 2'd3
   } cmd_kind_type;

   // Classified command: clamped operands kept as offsets from the range minimum
   typedef struct packed {
      cmd_kind_type kind;
      logic [10:0]  motor_id;
      logic [20:0]  pos_off;
      logic [20:0]  spd_off;
      logic [24:0]  kp_off;
      logic [18:0]  kd_off;
      logic [21:0]  tq_off;
   } cmd_type;

   // One outgoing CAN frame
   typedef struct packed {
      logic [10:0] frame_id;
      logic [63:0] payload;
      logic        last_frame;
   } frame_type;

   // Queue sizes
   localparam int CMD_DEPTH     = 4;
   localparam int CMD_PTR_W     = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W     = $clog2(CMD_DEPTH + 1);
   localparam int FRAME_DEPTH   = 8;
   localparam int FRAME_PTR_W   = $clog2(FRAME_DEPTH);
   localparam int FRAME_CNT_W   = $clog2(FRAME_DEPTH + 1);

   // Protocol bytes and identifiers
   localparam logic [10:0] BROADCAST_ID  = 11'h7FF;
   localparam logic [7:0]  BYTE_ENABLE   = 8'hFC;
   localparam logic [7:0]  BYTE_DISABLE  = 8'hFD;
   localparam logic [7:0]  BYTE_FEEDBACK = 8'hCC;
   localparam logic [7:0]  BYTE_REG_WR   = 8'h55;
   localparam logic [7:0]  REG_MODE      = 8'h0A;
   localparam logic [7:0]  MODE_CODE_RST = 8'h01;

   // Clamp bounds, Q16.16
   localparam logic signed [31:0] POS_MIN = -32'sd819200;
   localparam logic signed [31:0] POS_MAX = 32'sd819200;
   localparam logic signed [31:0] SPD_MIN = -32'sd655360;
   localparam logic signed [31:0] SPD_MAX = 32'sd655360;
   localparam logic signed [31:0] KP_MIN  = 32'sd0;
   localparam logic signed [31:0] KP_MAX  = 32'sd32768000;
   localparam logic signed [31:0] KD_MIN  = 32'sd0;
   localparam logic signed [31:0] KD_MAX  = 32'sd327680;
   localparam logic signed [31:0] TQ_MIN  = -32'sd1835008;
   localparam logic signed [31:0] TQ_MAX  = 32'sd1835008;

   // Quantizer: span = divisor * 2^shift, code width in bits
   localparam int POS_CODE_BITS = 16;
   localparam int LOW_BITS = 12;
   localparam int POS_SHIFT = 16;
   localparam int SPD_SHIFT = 18;
   localparam int KP_SHIFT  = 18;
   localparam int KD_SHIFT  = 16;
   localparam int TQ_SHIFT  = 19;
   localparam logic [6:0] POS_DIV = 7'd25;
   localparam logic [6:0] SPD_DIV = 7'd5;
   localparam logic [6:0] KP_DIV  = 7'd125;
   localparam logic [6:0] KD_DIV  = 7'd5;
   localparam logic [6:0] TQ_DIV  = 7'd7;

   // Reciprocals floor(2^RECIP_SHIFT / divisor); estimate is low by at most one
   localparam int RECIP_SHIFT = 24;
   localparam logic [21:0] POS_RECIP = 22'(2 ** RECIP_SHIFT / 25);
   localparam logic [21:0] SPD_RECIP = 22'(2 ** RECIP_SHIFT / 5);
   localparam logic [21:0] KP_RECIP  = 22'(2 ** RECIP_SHIFT / 125);
   localparam logic [21:0] KD_RECIP  = 22'(2 ** RECIP_SHIFT / 5);
   localparam logic [21:0] TQ_RECIP  = 22'(2 ** RECIP_SHIFT / 7);

   // Saturate to [lo, hi] and return the distance from lo
   function automatic logic [24:0] clamp_offset(logic signed [31:0] v,
                                                logic signed [31:0] lo,
                                                logic signed [31:0] hi);
      logic signed [31:0] vc;
      logic [31:0]        d;
      if (v < lo) begin
         vc = lo;
      end else if (v > hi) begin
         vc = hi;
      end else begin
         vc = v;
      end
      d = 32'(vc - lo);
      return d[24:0];
   endfunction

   // Multiply by 2^bits - 1, then drop the power-of-two part of the span
   function automatic logic [20:0] scale_shift(logic [24:0] x, int unsigned bits,
                                               int unsigned shift);
      logic [40:0] xw;
      logic [40:0] p;
      xw = {16'b0, x};
      p  = (xw << bits) - xw;
      return 21'(p >> shift);
   endfunction

   // Quotient estimate by reciprocal multiply
   function automatic logic [15:0] recip_estimate(logic [20:0] y, logic [21:0] k);
      logic [42:0] m;
      m = {22'b0, y} * {21'b0, k};
      return m[RECIP_SHIFT +: 16];
   endfunction

   // Fix the estimate with one compare against the remainder
   function automatic logic [15:0] round_fix(logic [20:0] y, logic [15:0] qe,
                                             logic [6:0] d);
      logic [22:0] prod;
      logic [22:0] r;
      prod = {7'b0, qe} * {16'b0, d};
      r    = {2'b0, y} - prod;
      return (r >= {16'b0, d}) ? qe + 16'd1 : qe;
   endfunction

endpackage

FILE: design/cmfb_front.sv
module cmfb_front (
   input  logic               [1:0]  req_mode,
   input  logic               [10:0] req_motor_id,
   input  logic signed        [31:0] req_target_position,
   input  logic signed        [31:0] req_target_speed,
   input  logic signed        [31:0] req_stiffness_gain,
   input  logic signed        [31:0] req_damping_gain,
   input  logic signed        [31:0] req_target_torque,
   output cmfb_pkg::cmd_type         cmd
);

   logic [24:0] pos_c;
   logic [24:0] spd_c;
   logic [24:0] kp_c;
   logic [24:0] kd_c;
   logic [24:0] tq_c;

   // Saturate each MIT operand and take its offset from the range minimum
   assign pos_c = cmfb_pkg::clamp_offset(req_target_position, cmfb_pkg::POS_MIN,
                                         cmfb_pkg::POS_MAX);
   assign spd_c = cmfb_pkg::clamp_offset(req_target_speed, cmfb_pkg::SPD_MIN,
                                         cmfb_pkg::SPD_MAX);
   assign kp_c  = cmfb_pkg::clamp_offset(req_stiffness_gain, cmfb_pkg::KP_MIN,
                                         cmfb_pkg::KP_MAX);
   assign kd_c  = cmfb_pkg::clamp_offset(req_damping_gain, cmfb_pkg::KD_MIN,
                                         cmfb_pkg::KD_MAX);
   assign tq_c  = cmfb_pkg::clamp_offset(req_target_torque, cmfb_pkg::TQ_MIN,
                                         cmfb_pkg::TQ_MAX);

   // Classify the command and pack it for the command queue
   always_comb begin
      cmd.kind     = cmfb_pkg::cmd_kind_type'(req_mode);
      cmd.motor_id = req_motor_id;
      cmd.pos_off  = pos_c[20:0];
      cmd.spd_off  = spd_c[20:0];
      cmd.kp_off   = kp_c;
      cmd.kd_off   = kd_c[18:0];
      cmd.tq_off   = tq_c[21:0];
   end

endmodule

FILE: design/cmfb_cmd_queue.sv
module cmfb_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  cmfb_pkg::cmd_type push_data,
   output logic              full,
   input  logic              pop,
   output cmfb_pkg::cmd_type head,
   output logic              head_valid
);

   cmfb_pkg::cmd_type                    mem_ff [cmfb_pkg::CMD_DEPTH];
   logic [cmfb_pkg::CMD_PTR_W-1:0]       wr_ptr_ff;
   logic [cmfb_pkg::CMD_PTR_W-1:0]       wr_ptr_in;
   logic [cmfb_pkg::CMD_PTR_W-1:0]       rd_ptr_ff;
   logic [cmfb_pkg::CMD_PTR_W-1:0]       rd_ptr_in;
   logic [cmfb_pkg::CMD_CNT_W-1:0]       count_ff;
   logic [cmfb_pkg::CMD_CNT_W-1:0]       count_in;
   logic                                 do_push;
   logic                                 do_pop;

   assign full       = (count_ff == cmfb_pkg::CMD_CNT_W'(cmfb_pkg::CMD_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + cmfb_pkg::CMD_CNT_W'(do_push)
                           - cmfb_pkg::CMD_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the entry on a transfer
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: design/cmfb_back.sv
module cmfb_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [7:0]                           csr_wdata,
   input  cmfb_pkg::cmd_type                    head,
   input  logic                                 head_valid,
   output logic                                 head_pop,
   input  logic [cmfb_pkg::FRAME_CNT_W-1:0]     frame_count,
   output logic                                 frame_push,
   output cmfb_pkg::frame_type                  frame
);

   typedef enum logic [2:0] {
      FRM_ENABLE,
      FRM_DISABLE,
      FRM_FEEDBACK,
      FRM_SWITCH,
      FRM_MIT
   } frame_op_type;

   typedef struct packed {
      frame_op_type op;
      logic [10:0]  motor_id;
      logic [20:0]  pos_off;
      logic [20:0]  spd_off;
      logic [24:0]  kp_off;
      logic [18:0]  kd_off;
      logic [21:0]  tq_off;
   } issue_type;

   typedef struct packed {
      frame_op_type op;
      logic [10:0]  motor_id;
      logic [20:0]  pos_y;
      logic [14:0]  spd_y;
      logic [18:0]  kp_y;
      logic [14:0]  kd_y;
      logic [14:0]  tq_y;
   } scaled_type;

   typedef struct packed {
      scaled_type   s;
      logic [15:0]  pos_qe;
      logic [11:0]  spd_qe;
      logic [11:0]  kp_qe;
      logic [11:0]  kd_qe;
      logic [11:0]  tq_qe;
   } estimate_type;

   logic [7:0]                        mode_code_ff;
   logic                              phase_ff;
   logic                              phase_in;
   logic                              st0_v_ff;
   logic                              st1_v_ff;
   logic                              st2_v_ff;
   issue_type                         st0_ff;
   issue_type                         st0_in;
   scaled_type                        st1_ff;
   scaled_type                        st1_in;
   estimate_type                      st2_ff;
   estimate_type                      st2_in;
   logic [cmfb_pkg::FRAME_CNT_W:0]    committed;
   logic                              issue;
   logic                              is_mit;
   logic [20:0]                       sc_pos;
   logic [20:0]                       sc_spd;
   logic [20:0]                       sc_kp;
   logic [20:0]                       sc_kd;
   logic [20:0]                       sc_tq;
   logic [15:0]                       es_pos;
   logic [15:0]                       es_spd;
   logic [15:0]                       es_kp;
   logic [15:0]                       es_kd;
   logic [15:0]                       es_tq;
   logic [15:0]                       q_pos;
   logic [15:0]                       q_spd;
   logic [15:0]                       q_kp;
   logic [15:0]                       q_kd;
   logic [15:0]                       q_tq;

   // Hold the mode byte for the register-write frame
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_code_ff <= cmfb_pkg::MODE_CODE_RST;
      end else if (csr_we) begin
         mode_code_ff <= csr_wdata;
      end
   end

   // Issue only when the frame queue has room for everything in flight
   assign committed = (cmfb_pkg::FRAME_CNT_W + 1)'(frame_count)
                    + (cmfb_pkg::FRAME_CNT_W + 1)'(st0_v_ff)
                    + (cmfb_pkg::FRAME_CNT_W + 1)'(st1_v_ff)
                    + (cmfb_pkg::FRAME_CNT_W + 1)'(st2_v_ff);
   assign issue     = head_valid
                   && (committed < (cmfb_pkg::FRAME_CNT_W + 1)'(cmfb_pkg::FRAME_DEPTH));
   assign is_mit    = (head.kind == cmfb_pkg::CMD_MIT);

   // An MIT command issues the register write first, then the MIT frame
   assign head_pop = issue && !(is_mit && !phase_ff);
   assign phase_in = (issue && is_mit) ? !phase_ff : phase_ff;

   always_comb begin
      st0_in.motor_id = head.motor_id;
      st0_in.pos_off  = head.pos_off;
      st0_in.spd_off  = head.spd_off;
      st0_in.kp_off   = head.kp_off;
      st0_in.kd_off   = head.kd_off;
      st0_in.tq_off   = head.tq_off;
      unique case (head.kind)
         cmfb_pkg::CMD_ENABLE:   st0_in.op = FRM_ENABLE;
         cmfb_pkg::CMD_DISABLE:  st0_in.op = FRM_DISABLE;
         cmfb_pkg::CMD_FEEDBACK: st0_in.op = FRM_FEEDBACK;
         cmfb_pkg::CMD_MIT:      st0_in.op = phase_ff ? FRM_MIT : FRM_SWITCH;
         default:                st0_in.op = FRM_ENABLE;
      endcase
   end

   // Scale by the code range and drop the power-of-two part of the span
   assign sc_pos = cmfb_pkg::scale_shift(25'(st0_ff.pos_off), cmfb_pkg::POS_CODE_BITS,
                                         cmfb_pkg::POS_SHIFT);
   assign sc_spd = cmfb_pkg::scale_shift(25'(st0_ff.spd_off), cmfb_pkg::LOW_BITS,
                                         cmfb_pkg::SPD_SHIFT);
   assign sc_kp  = cmfb_pkg::scale_shift(st0_ff.kp_off, cmfb_pkg::LOW_BITS,
                                         cmfb_pkg::KP_SHIFT);
   assign sc_kd  = cmfb_pkg::scale_shift(25'(st0_ff.kd_off), cmfb_pkg::LOW_BITS,
                                         cmfb_pkg::KD_SHIFT);
   assign sc_tq  = cmfb_pkg::scale_shift(25'(st0_ff.tq_off), cmfb_pkg::LOW_BITS,
                                         cmfb_pkg::TQ_SHIFT);

   always_comb begin
      st1_in.op       = st0_ff.op;
      st1_in.motor_id = st0_ff.motor_id;
      st1_in.pos_y    = sc_pos;
      st1_in.spd_y    = sc_spd[14:0];
      st1_in.kp_y     = sc_kp[18:0];
      st1_in.kd_y     = sc_kd[14:0];
      st1_in.tq_y     = sc_tq[14:0];
   end

   // Estimate the odd part of the division by reciprocal multiply
   assign es_pos = cmfb_pkg::recip_estimate(st1_ff.pos_y, cmfb_pkg::POS_RECIP);
   assign es_spd = cmfb_pkg::recip_estimate(21'(st1_ff.spd_y), cmfb_pkg::SPD_RECIP);
   assign es_kp  = cmfb_pkg::recip_estimate(21'(st1_ff.kp_y), cmfb_pkg::KP_RECIP);
   assign es_kd  = cmfb_pkg::recip_estimate(21'(st1_ff.kd_y), cmfb_pkg::KD_RECIP);
   assign es_tq  = cmfb_pkg::recip_estimate(21'(st1_ff.tq_y), cmfb_pkg::TQ_RECIP);

   always_comb begin
      st2_in.s      = st1_ff;
      st2_in.pos_qe = es_pos;
      st2_in.spd_qe = es_spd[11:0];
      st2_in.kp_qe  = es_kp[11:0];
      st2_in.kd_qe  = es_kd[11:0];
      st2_in.tq_qe  = es_tq[11:0];
   end

   // Correct each estimate against its remainder
   assign q_pos = cmfb_pkg::round_fix(st2_ff.s.pos_y, st2_ff.pos_qe, cmfb_pkg::POS_DIV);
   assign q_spd = cmfb_pkg::round_fix(21'(st2_ff.s.spd_y), 16'(st2_ff.spd_qe),
                                      cmfb_pkg::SPD_DIV);
   assign q_kp  = cmfb_pkg::round_fix(21'(st2_ff.s.kp_y), 16'(st2_ff.kp_qe),
                                      cmfb_pkg::KP_DIV);
   assign q_kd  = cmfb_pkg::round_fix(21'(st2_ff.s.kd_y), 16'(st2_ff.kd_qe),
                                      cmfb_pkg::KD_DIV);
   assign q_tq  = cmfb_pkg::round_fix(21'(st2_ff.s.tq_y), 16'(st2_ff.tq_qe),
                                      cmfb_pkg::TQ_DIV);

   // Build the frame at the end of the pipeline
   assign frame_push = st2_v_ff;

   always_comb begin
      frame.frame_id   = st2_ff.s.motor_id;
      frame.last_frame = 1'b1;
      frame.payload    = '0;
      unique case (st2_ff.s.op)
         FRM_ENABLE: begin
            frame.payload = {56'hFF_FFFF_FFFF_FFFF, cmfb_pkg::BYTE_ENABLE};
         end
         FRM_DISABLE: begin
            frame.payload = {56'hFF_FFFF_FFFF_FFFF, cmfb_pkg::BYTE_DISABLE};
         end
         FRM_FEEDBACK: begin
            frame.frame_id = cmfb_pkg::BROADCAST_ID;
            frame.payload  = {st2_ff.s.motor_id[7:0], 5'b0, st2_ff.s.motor_id[10:8],
                              cmfb_pkg::BYTE_FEEDBACK, 40'h0};
         end
         FRM_SWITCH: begin
            frame.frame_id   = cmfb_pkg::BROADCAST_ID;
            frame.last_frame = 1'b0;
            frame.payload    = {st2_ff.s.motor_id[7:0], 5'b0, st2_ff.s.motor_id[10:8],
                                cmfb_pkg::BYTE_REG_WR, cmfb_pkg::REG_MODE,
                                mode_code_ff, 24'h0};
         end
         FRM_MIT: begin
            frame.payload = {q_pos, q_spd[11:0], q_kp[11:0], q_kd[11:0], q_tq[11:0]};
         end
         default: begin
            frame.payload = '0;
         end
      endcase
   end

   // Advance the pipeline valid bits and the MIT phase
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
         st0_v_ff <= 1'b0;
         st1_v_ff <= 1'b0;
         st2_v_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         st0_v_ff <= issue;
         st1_v_ff <= st0_v_ff;
         st2_v_ff <= st1_v_ff;
      end
   end

   // Pipeline payload
   always_ff @(posedge clock) begin
      st0_ff <= st0_in;
      st1_ff <= st1_in;
      st2_ff <= st2_in;
   end

endmodule

FILE: design/cmfb_frame_queue.sv
module cmfb_frame_queue (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   input  cmfb_pkg::frame_type                push_data,
   output logic [cmfb_pkg::FRAME_CNT_W-1:0]   count,
   input  logic                               pop,
   output cmfb_pkg::frame_type                head,
   output logic                               empty
);

   cmfb_pkg::frame_type                  mem_ff [cmfb_pkg::FRAME_DEPTH];
   logic [cmfb_pkg::FRAME_PTR_W-1:0]     wr_ptr_ff;
   logic [cmfb_pkg::FRAME_PTR_W-1:0]     wr_ptr_in;
   logic [cmfb_pkg::FRAME_PTR_W-1:0]     rd_ptr_ff;
   logic [cmfb_pkg::FRAME_PTR_W-1:0]     rd_ptr_in;
   logic [cmfb_pkg::FRAME_CNT_W-1:0]     count_ff;
   logic [cmfb_pkg::FRAME_CNT_W-1:0]     count_in;
   logic                                 do_push;
   logic                                 do_pop;

   assign count   = count_ff;
   assign empty   = (count_ff == '0);
   assign head    = mem_ff[rd_ptr_ff];
   assign do_push = push && (count_ff != cmfb_pkg::FRAME_CNT_W'(cmfb_pkg::FRAME_DEPTH));
   assign do_pop  = pop && !empty;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + cmfb_pkg::FRAME_CNT_W'(do_push)
                           - cmfb_pkg::FRAME_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the frame
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: design/motor_command_frame_builder.sv
// Motor command to CAN frame builder. Push one command per transfer on req_*;
// the frames that carry it come out in transmission order on rsp_*, a queue
// read side (rsp_empty low means a frame is shown, rsp_pop takes it). Enable,
// disable and feedback request give one frame; an MIT command gives two, a
// mode-switch register write to 0x7FF followed by the packed MIT frame, and
// rsp_last_frame marks the final frame of each command. The frame sequencer
// issues one frame per cycle while rsp_pop keeps up, so single-frame commands
// sustain one per cycle and an MIT command takes an issue slot for each of its
// two frames. With the block idle, the first frame of a command passes the
// command queue, the issue register, the scale stage and the reciprocal-multiply
// stage, with the correction feeding the frame queue directly; the MIT frame
// follows in the next cycle. req_full rises when four commands wait. csr_wdata
// sets the mode byte of the register write (1 after reset); write it only while
// no command is in flight.
module motor_command_frame_builder (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic        [7:0]  csr_wdata,
   input  logic               req_push,
   output logic               req_full,
   input  logic        [1:0]  req_mode,
   input  logic        [10:0] req_motor_id,
   input  logic signed [31:0] req_target_position,
   input  logic signed [31:0] req_target_speed,
   input  logic signed [31:0] req_stiffness_gain,
   input  logic signed [31:0] req_damping_gain,
   input  logic signed [31:0] req_target_torque,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic        [10:0] rsp_frame_id,
   output logic        [63:0] rsp_payload,
   output logic               rsp_last_frame
);

   cmfb_pkg::cmd_type                      cmd;
   cmfb_pkg::cmd_type                      head;
   logic                                   head_valid;
   logic                                   head_pop;
   logic [cmfb_pkg::FRAME_CNT_W-1:0]       frame_count;
   logic                                   frame_push;
   cmfb_pkg::frame_type                    frame;
   cmfb_pkg::frame_type                    out_frame;

   // Classify and clamp incoming commands
   cmfb_front u_front (
      .req_mode            (req_mode),
      .req_motor_id        (req_motor_id),
      .req_target_position (req_target_position),
      .req_target_speed    (req_target_speed),
      .req_stiffness_gain  (req_stiffness_gain),
      .req_damping_gain    (req_damping_gain),
      .req_target_torque   (req_target_torque),
      .cmd                 (cmd)
   );

   // Decouple intake from frame generation
   cmfb_cmd_queue u_cmd_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .push_data  (cmd),
      .full       (req_full),
      .pop        (head_pop),
      .head       (head),
      .head_valid (head_valid)
   );

   // Sequence frames and quantize MIT operands
   cmfb_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .head        (head),
      .head_valid  (head_valid),
      .head_pop    (head_pop),
      .frame_count (frame_count),
      .frame_push  (frame_push),
      .frame       (frame)
   );

   // Hold finished frames until taken
   cmfb_frame_queue u_frame_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (frame_push),
      .push_data (frame),
      .count     (frame_count),
      .pop       (rsp_pop),
      .head      (out_frame),
      .empty     (rsp_empty)
   );

   assign rsp_frame_id   = out_frame.frame_id;
   assign rsp_payload    = out_frame.payload;
   assign rsp_last_frame = out_frame.last_frame;

endmodule

FILE: dv/motor_command_frame_builder_tb.sv
`timescale 1ns / 100ps

module motor_command_frame_builder_tb;

   // Clamp bounds in Q16.16
   localparam int POS_LO = -819200;
   localparam int POS_HI = 819200;
   localparam int SPD_LO = -655360;
   localparam int SPD_HI = 655360;
   localparam int KP_LO  = 0;
   localparam int KP_HI  = 32768000;
   localparam int KD_LO  = 0;
   localparam int KD_HI  = 327680;
   localparam int TQ_LO  = -1835008;
   localparam int TQ_HI  = 1835008;

   // Cycles to let pass after the last frame before touching the mode register
   localparam int SETTLE_CYCLES = 12;

   typedef struct {
      cmfb_pkg::cmd_kind_type kind;
      logic [10:0]            motor_id;
      logic signed [31:0]     position;
      logic signed [31:0]     speed;
      logic signed [31:0]     kp;
      logic signed [31:0]     kd;
      logic signed [31:0]     torque;
   } motor_cmd_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_we = 1'b0;
   logic        [7:0]  csr_wdata = 8'h00;
   logic               req_push = 1'b0;
   logic               req_full;
   logic        [1:0]  req_mode = 2'd0;
   logic        [10:0] req_motor_id = 11'd0;
   logic signed [31:0] req_target_position = 32'sd0;
   logic signed [31:0] req_target_speed = 32'sd0;
   logic signed [31:0] req_stiffness_gain = 32'sd0;
   logic signed [31:0] req_damping_gain = 32'sd0;
   logic signed [31:0] req_target_torque = 32'sd0;
   logic               rsp_empty;
   logic               rsp_pop = 1'b0;
   logic        [10:0] rsp_frame_id;
   logic        [63:0] rsp_payload;
   logic               rsp_last_frame;

   cmfb_pkg::frame_type  expected_frames[$];
   logic [7:0]           mode_code_model = cmfb_pkg::MODE_CODE_RST;
   int                   fail_count = 0;
   int                   frames_checked = 0;
   int                   commands_by_kind[4] = '{0, 0, 0, 0};
   bit                   sender_idle = 1'b0;
   bit                   receiver_idle = 1'b0;
   int                   stall_left = 0;
   cmfb_pkg::frame_type  want;

   motor_command_frame_builder dut (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_wdata           (csr_wdata),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_mode            (req_mode),
      .req_motor_id        (req_motor_id),
      .req_target_position (req_target_position),
      .req_target_speed    (req_target_speed),
      .req_stiffness_gain  (req_stiffness_gain),
      .req_damping_gain    (req_damping_gain),
      .req_target_torque   (req_target_torque),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_frame_id        (rsp_frame_id),
      .rsp_payload         (rsp_payload),
      .rsp_last_frame      (rsp_last_frame)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Clamp, then floor((v - lo) * (2^bits - 1) / (hi - lo)) in exact integers
   function automatic logic [15:0] quantize_code(logic signed [31:0] v, longint lo,
                                                 longint hi, int bits);
      longint x;
      longint top;
      x   = v;
      top = (longint'(1) << bits) - 1;
      if (x < lo) x = lo;
      if (x > hi) x = hi;
      return 16'((x - lo) * top / (hi - lo));
   endfunction

   // Queue the frames that one accepted command must produce
   function automatic void predict_frames(cmfb_pkg::cmd_kind_type kind, logic [10:0] id,
                                          logic signed [31:0] pos, logic signed [31:0] spd,
                                          logic signed [31:0] kp, logic signed [31:0] kd,
                                          logic signed [31:0] tq);
      cmfb_pkg::frame_type f;
      logic [15:0]         pq, sq, kpq, kdq, tqq;
      case (kind)
         cmfb_pkg::CMD_ENABLE, cmfb_pkg::CMD_DISABLE: begin
            f.frame_id   = id;
            f.payload    = {56'hFF_FFFF_FFFF_FFFF, (kind == cmfb_pkg::CMD_ENABLE) ?
                            cmfb_pkg::BYTE_ENABLE : cmfb_pkg::BYTE_DISABLE};
            f.last_frame = 1'b1;
            expected_frames.push_back(f);
         end
         cmfb_pkg::CMD_FEEDBACK: begin
            f.frame_id   = cmfb_pkg::BROADCAST_ID;
            f.payload    = {id[7:0], 5'b0, id[10:8], cmfb_pkg::BYTE_FEEDBACK, 40'h0};
            f.last_frame = 1'b1;
            expected_frames.push_back(f);
         end
         default: begin
            f.frame_id   = cmfb_pkg::BROADCAST_ID;
            f.payload    = {id[7:0], 5'b0, id[10:8], cmfb_pkg::BYTE_REG_WR,
                            cmfb_pkg::REG_MODE, mode_code_model, 24'h0};
            f.last_frame = 1'b0;
            expected_frames.push_back(f);
            pq  = quantize_code(pos, POS_LO, POS_HI, 16);
            sq  = quantize_code(spd, SPD_LO, SPD_HI, 12);
            kpq = quantize_code(kp, KP_LO, KP_HI, 12);
            kdq = quantize_code(kd, KD_LO, KD_HI, 12);
            tqq = quantize_code(tq, TQ_LO, TQ_HI, 12);
            f.frame_id   = id;
            f.payload    = {pq, sq[11:0], kpq[11:0], kdq[11:0], tqq[11:0]};
            f.last_frame = 1'b1;
            expected_frames.push_back(f);
         end
      endcase
   endfunction

   // Check each frame transfer, predict from each command transfer, pace rsp_pop
   always @(posedge clock) begin
      if (reset) begin
         stall_left = 0;
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            frames_checked++;
            if (expected_frames.size() == 0) begin
               $error("unexpected frame: frame_id %h payload %h last_frame %b",
                      rsp_frame_id, rsp_payload, rsp_last_frame);
               fail_count++;
            end else begin
               want = expected_frames.pop_front();
               if (rsp_frame_id !== want.frame_id) begin
                  $error("frame_id: expected %h, actual %h", want.frame_id, rsp_frame_id);
                  fail_count++;
               end
               if (rsp_payload !== want.payload) begin
                  $error("payload: expected %h, actual %h", want.payload, rsp_payload);
                  fail_count++;
               end
               if (rsp_last_frame !== want.last_frame) begin
                  $error("last_frame: expected %b, actual %b", want.last_frame,
                         rsp_last_frame);
                  fail_count++;
               end
            end
         end
         if (req_push && !req_full) begin
            commands_by_kind[req_mode]++;
            predict_frames(cmfb_pkg::cmd_kind_type'(req_mode), req_motor_id,
                           req_target_position, req_target_speed, req_stiffness_gain,
                           req_damping_gain, req_target_torque);
         end
         if (csr_we) mode_code_model = csr_wdata;
         // Hold pop low through a stall burst, otherwise take a frame
         if (stall_left > 0) begin
            stall_left--;
            rsp_pop <= 1'b0;
         end else if (receiver_idle && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 17) - 1;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // Offer one command and hold it until the transfer
   task automatic send_command(input motor_cmd_type c);
      int gap;
      gap = 0;
      if (sender_idle && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 17);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push            <= 1'b1;
      req_mode            <= c.kind;
      req_motor_id        <= c.motor_id;
      req_target_position <= c.position;
      req_target_speed    <= c.speed;
      req_stiffness_gain  <= c.kp;
      req_damping_gain    <= c.kd;
      req_target_torque   <= c.torque;
      do @(posedge clock); while (req_full);
   endtask

   // Stop sending and wait until every queued frame has been taken
   task automatic wait_until_drained();
      req_push <= 1'b0;
      @(posedge clock);
      while (expected_frames.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode_code(input logic [7:0] code);
      wait_until_drained();
      csr_we    <= 1'b1;
      csr_wdata <= code;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic motor_cmd_type make_command(cmfb_pkg::cmd_kind_type kind,
                                                  logic [10:0] id, int pos, int spd,
                                                  int kp, int kd, int tq);
      motor_cmd_type c;
      c.kind     = kind;
      c.motor_id = id;
      c.position = pos;
      c.speed    = spd;
      c.kp       = kp;
      c.kd       = kd;
      c.torque   = tq;
      return c;
   endfunction

   // Mostly in range, some at the bounds, some raw or extreme words
   function automatic logic signed [31:0] random_operand(int lo, int hi);
      case ($urandom_range(0, 5))
         0, 1, 2: return lo + int'($urandom_range(0, hi - lo));
         3:       return (($urandom_range(0, 1) == 1) ? hi : lo)
                         + int'($urandom_range(0, 6)) - 3;
         4:       return $urandom;
         default: begin
            case ($urandom_range(0, 3))
               0:       return 32'h8000_0000;
               1:       return 32'h7FFF_FFFF;
               2:       return 32'h0000_0000;
               default: return 32'hFFFF_FFFF;
            endcase
         end
      endcase
   endfunction

   function automatic motor_cmd_type random_command();
      motor_cmd_type c;
      c.kind     = cmfb_pkg::cmd_kind_type'($urandom_range(0, 3));
      c.motor_id = 11'($urandom);
      c.position = random_operand(POS_LO, POS_HI);
      c.speed    = random_operand(SPD_LO, SPD_HI);
      c.kp       = random_operand(KP_LO, KP_HI);
      c.kd       = random_operand(KD_LO, KD_HI);
      c.torque   = random_operand(TQ_LO, TQ_HI);
      return c;
   endfunction

   task automatic test_default_mode_code();
      send_command(make_command(cmfb_pkg::CMD_MIT, 11'h123, 0, 0, 0, 0, 0));
   endtask

   task automatic test_enable_disable();
      send_command(make_command(cmfb_pkg::CMD_ENABLE, 11'h000, 0, 0, 0, 0, 0));
      send_command(make_command(cmfb_pkg::CMD_ENABLE, 11'h7FF, -1, -1, -1, -1, -1));
      send_command(make_command(cmfb_pkg::CMD_DISABLE, 11'h000, 0, 0, 0, 0, 0));
      send_command(make_command(cmfb_pkg::CMD_DISABLE, 11'h7FF, 0, 0, 0, 0, 0));
      send_command(make_command(cmfb_pkg::CMD_DISABLE, 11'h2A5, 0, 0, 0, 0, 0));
   endtask

   task automatic test_feedback_request();
      send_command(make_command(cmfb_pkg::CMD_FEEDBACK, 11'h000, 0, 0, 0, 0, 0));
      send_command(make_command(cmfb_pkg::CMD_FEEDBACK, 11'h7FF, 0, 0, 0, 0, 0));
      send_command(make_command(cmfb_pkg::CMD_FEEDBACK, 11'h155, -1, -1, -1, -1, -1));
   endtask

   // Saturation below and above, the exact bounds, and values around zero
   task automatic test_mit_clamping();
      send_command(make_command(cmfb_pkg::CMD_MIT, 11'h7FF, 32'h8000_0000, 32'h8000_0000,
                                32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
      send_command(make_command(cmfb_pkg::CMD_MIT, 11'h000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
      send_command(make_command(cmfb_pkg::CMD_MIT, 11'h555, POS_LO, SPD_LO, KP_LO,
                                KD_LO, TQ_LO));
      send_command(make_command(cmfb_pkg::CMD_MIT, 11'h2AA, POS_HI, SPD_HI, KP_HI,
                                KD_HI, TQ_HI));
      send_command(make_command(cmfb_pkg::CMD_MIT, 11'h0F0, POS_LO - 1, SPD_LO - 1,
                                KP_LO - 1, KD_LO - 1, TQ_LO - 1));
      send_command(make_command(cmfb_pkg::CMD_MIT, 11'h70F, POS_HI + 1, SPD_HI + 1,
                                KP_HI + 1, KD_HI + 1, TQ_HI + 1));
      send_command(make_command(cmfb_pkg::CMD_MIT, 11'h001, POS_LO + 1, SPD_HI - 1,
                                KP_HI - 1, KD_LO + 1, TQ_HI - 1));
      send_command(make_command(cmfb_pkg::CMD_MIT, 11'h400, 1, -1, 1, 1, -1));
   endtask

   task automatic test_mode_code_extremes();
      write_mode_code(8'h00);
      send_command(make_command(cmfb_pkg::CMD_MIT, 11'h3C3, 65536, -65536, 655360,
                                32768, 0));
      write_mode_code(8'hFF);
      send_command(make_command(cmfb_pkg::CMD_MIT, 11'h7FF, 0, 0, 0, 0, 0));
      write_mode_code(8'hA5);
      send_command(make_command(cmfb_pkg::CMD_MIT, 11'h000, -1, 1, -1, -1, 1));
   endtask

   task automatic test_random_traffic(input int count, input logic [7:0] code);
      write_mode_code(code);
      repeat (count) send_command(random_command());
   endtask

   // Hold the sender off in mid stream until every frame has been taken
   task automatic test_pause_until_drained(input int count);
      repeat (count) send_command(random_command());
      wait_until_drained();
      repeat (count) send_command(random_command());
   endtask

   task automatic test_streaming_no_idle(input int count);
      sender_idle   = 1'b0;
      receiver_idle = 1'b0;
      write_mode_code(8'($urandom));
      repeat (count) send_command(random_command());
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_default_mode_code();
      test_enable_disable();
      test_feedback_request();
      test_mit_clamping();
      test_mode_code_extremes();

      sender_idle   = 1'b1;
      receiver_idle = 1'b1;
      test_random_traffic(160, 8'($urandom));
      test_random_traffic(160, 8'h00);
      test_random_traffic(160, 8'hFF);
      test_pause_until_drained(60);
      test_streaming_no_idle(120);
      wait_until_drained();

      $display("Checked %0d frames from %0d enable, %0d disable, %0d MIT, %0d feedback",
               frames_checked, commands_by_kind[cmfb_pkg::CMD_ENABLE],
               commands_by_kind[cmfb_pkg::CMD_DISABLE],
               commands_by_kind[cmfb_pkg::CMD_MIT],
               commands_by_kind[cmfb_pkg::CMD_FEEDBACK]);
      $display("Mode code reset value, 0, 255 and random codes; clamp edges and saturation hit");
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Watchdog well past the slowest legal run
   initial begin
      #2000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
